// File: rtl/crlf_pkg.sv
package crlf_pkg;

  // Default depth of the line store in bytes
  localparam int unsigned LineDepthDefault = 64;

  // Framing characters and default timeout
  localparam logic [7:0]  CharCr         = 8'h0D;
  localparam logic [7:0]  CharLf         = 8'h0A;
  localparam logic [31:0] TimeoutDefault = 32'd5000;

  // Input transaction kinds (carried in tuser)
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_LINKERR = 2'd2,
    OP_GO_IDLE = 2'd3
  } op_e;

  // Result kinds (carried in tuser)
  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_TIMEOUT  = 3'd2,
    KIND_LINKERR  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_ENABLE  = 1'd0,
    REG_TIMEOUT = 1'd1
  } reg_e;

  // One result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// File: rtl/crlf_out_reg.sv
module crlf_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  crlf_pkg::res_t res_i,
  output logic          free_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,   // data[7:0]
  output logic [2:0]    m_axis_tuser,   // kind[2:0]
  output logic          m_axis_tlast
);
  import crlf_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Register can load when empty or when its content leaves this cycle
  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = free_o ? push_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q.data;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;

endmodule

// File: rtl/crlf_line_deframer_core.sv
// CR LF line deframer. Input transactions carry an operation in tuser (byte, tick, link
// error, go idle) and the received byte in tdata. A transaction is taken whenever no
// line is being walked and the result register has room; bytes are written into a
// LINE_DEPTH-byte line store. When LF completes a line that has payload and did not
// overflow, the block stops accepting and walks the store through its registered read
// port, reading and then handing over each payload byte until the last one is handed
// over. Ticks advance a saturating 32-bit idle counter; one compare against timeout_q
// decides the timeout. Timeout, link error, overflow and empty-line results are single
// transactions with tlast set. Configuration writes use cfg_we_i/cfg_idx_i/cfg_data_i.
module crlf_line_deframer_core #(
  parameter int unsigned LINE_DEPTH = crlf_pkg::LineDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // data[7:0]
  output logic [2:0]  m_axis_tuser,   // kind[2:0]
  output logic        m_axis_tlast
);
  import crlf_pkg::*;

  localparam int unsigned FW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam logic [FW-1:0] Depth = FW'(LINE_DEPTH);

  typedef enum logic [4:0] {
    M_IDLE    = 5'b00001,
    M_FIRST   = 5'b00010,
    M_WAIT_CR = 5'b00100,
    M_WAIT_LF = 5'b01000,
    M_ERROR   = 5'b10000
  } mode_e;

  typedef enum logic [2:0] {
    SEQ_RUN  = 3'b001,
    SEQ_RD   = 3'b010,
    SEQ_PUSH = 3'b100
  } seq_e;

  // Configuration registers
  logic        enable_q;
  logic [31:0] timeout_q;

  // Receiver state
  mode_e          mode_q, mode_d;
  seq_e           seq_q, seq_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [31:0]    ticks_q, ticks_d;
  logic           ovf_q, ovf_d;
  logic [FW-1:0]  len_q, len_d;
  logic [FW-1:0]  idx_q, idx_d;

  // Line store
  logic [7:0]     mem [LINE_DEPTH];
  logic [7:0]     rd_data_q;
  logic           wr_en;

  // Result handoff
  logic  push;
  res_t  res;
  logic  out_free;

  logic        accept;
  op_e         op;
  mode_e       eff_mode;
  logic        active;
  logic        full;
  logic [FW-1:0] fill_after;
  logic [31:0] ticks_inc;
  logic        idx_last;

  assign op            = op_e'(s_axis_tuser);
  assign s_axis_tready = (seq_q == SEQ_RUN) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (fill_q == Depth);
  assign fill_after    = full ? fill_q : fill_q + FW'(1);
  // Shared tick unit: saturating increment feeding one compare
  assign ticks_inc     = (ticks_q == '1) ? ticks_q : ticks_q + 32'd1;
  assign idx_last      = (idx_q + FW'(1) == len_q);

  // Per-transaction receiver step and emission sequencer
  always_comb begin
    mode_d   = mode_q;
    seq_d    = seq_q;
    fill_d   = fill_q;
    ticks_d  = ticks_q;
    ovf_d    = ovf_q;
    len_d    = len_q;
    idx_d    = idx_q;
    wr_en    = 1'b0;
    push     = 1'b0;
    res.kind = KIND_BYTE;
    res.data = 8'd0;
    res.last = 1'b1;
    eff_mode = mode_q;
    active   = 1'b0;

    unique case (seq_q)
      SEQ_RUN: begin
        if (accept) begin
          if (op == OP_GO_IDLE) begin
            mode_d = M_IDLE;
          end else begin
            active = (mode_q != M_ERROR) && ((mode_q != M_IDLE) || enable_q);
            if (mode_q == M_IDLE) begin
              eff_mode = M_FIRST;
            end
            if (active) begin
              mode_d = eff_mode;
              if (op == OP_LINKERR) begin
                mode_d   = M_ERROR;
                push     = 1'b1;
                res.kind = KIND_LINKERR;
              end else if (eff_mode == M_FIRST) begin
                if (op == OP_BYTE) begin
                  // New line: byte lands at entry zero
                  wr_en   = 1'b1;
                  fill_d  = FW'(1);
                  ovf_d   = 1'b0;
                  ticks_d = '0;
                  mode_d  = (s_axis_tdata == CharCr) ? M_WAIT_LF : M_WAIT_CR;
                end
              end else if (op == OP_TICK) begin
                ticks_d = ticks_inc;
                if (ticks_inc >= timeout_q) begin
                  mode_d   = M_FIRST;
                  push     = 1'b1;
                  res.kind = KIND_TIMEOUT;
                end
              end else begin
                // Byte inside a line
                ticks_d = '0;
                wr_en   = !full;
                fill_d  = fill_after;
                if (full) begin
                  ovf_d = 1'b1;
                end
                if (eff_mode == M_WAIT_CR) begin
                  if (s_axis_tdata == CharCr) begin
                    mode_d = M_WAIT_LF;
                  end
                end else if (s_axis_tdata == CharLf) begin
                  mode_d = M_FIRST;
                  if (ovf_q || full) begin
                    push     = 1'b1;
                    res.kind = KIND_OVERFLOW;
                  end else if (fill_after <= FW'(2)) begin
                    push     = 1'b1;
                    res.kind = KIND_EMPTY;
                  end else begin
                    len_d = fill_after - FW'(2);
                    idx_d = '0;
                    seq_d = SEQ_RD;
                  end
                end else begin
                  mode_d = M_WAIT_CR;
                end
              end
            end
          end
        end
      end
      SEQ_RD: begin
        seq_d = SEQ_PUSH;
      end
      SEQ_PUSH: begin
        res.kind = KIND_BYTE;
        res.data = rd_data_q;
        res.last = idx_last;
        if (out_free) begin
          push  = 1'b1;
          idx_d = idx_q + FW'(1);
          seq_d = idx_last ? SEQ_RUN : SEQ_RD;
        end
      end
      default: begin
        seq_d = SEQ_RUN;
      end
    endcase

    // Clearing enable pauses the receiver
    if (cfg_we_i && (cfg_idx_i == REG_ENABLE) && !cfg_data_i[0]) begin
      mode_d = M_IDLE;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      timeout_q <= TimeoutDefault;
      mode_q    <= M_IDLE;
      seq_q     <= SEQ_RUN;
      fill_q    <= '0;
      ticks_q   <= '0;
      ovf_q     <= 1'b0;
      len_q     <= '0;
      idx_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ENABLE:  enable_q  <= cfg_data_i[0];
          REG_TIMEOUT: timeout_q <= cfg_data_i;
          default:     enable_q  <= enable_q;
        endcase
      end
      mode_q  <= mode_d;
      seq_q   <= seq_d;
      fill_q  <= fill_d;
      ticks_q <= ticks_d;
      ovf_q   <= ovf_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  // Line store: write at the fill position, registered read at the walk index
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[(mode_d != M_IDLE && fill_d == FW'(1)) ? '0 : fill_q[AW-1:0]] <= s_axis_tdata;
    end
    if (seq_q == SEQ_RD) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

  crlf_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Fill count never passes the store depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Depth)
    else $error("fill count beyond line store depth");

  // Walk index stays inside the line being emitted
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_PUSH) |-> (idx_q < len_q))
    else $error("emit index past line length");

  // No input is taken during a walk
  a_no_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SEQ_RUN) |-> !s_axis_tready)
    else $error("input accepted while emitting a line");

  // Error mode holds until go idle or a pause
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_ERROR && !(accept && op == OP_GO_IDLE) && !cfg_we_i)
    |=> (mode_q == M_ERROR))
    else $error("error mode left without go idle");

endmodule
